/* rtl/core/product_quantizer_encoder_assert.svh */
// ----------------------------------------------------------------------------
// product_quantizer_encoder_assert.svh
// assertion macros for the product quantizer encoder, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef PRODUCT_QUANTIZER_ENCODER_ASSERT_SVH
`define PRODUCT_QUANTIZER_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PQE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqe assertion failed");
// next-cycle implication
`define PQE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqe assertion failed");
`else
`define PQE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PQE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/pqe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqe_pkg
// shared types and constants of the product quantizer encoder
// ----------------------------------------------------------------------------
package pqe_pkg;

   // function codes of an input transaction
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_ENCODE = 2'd1;
   localparam logic [1:0] FUNC_DIST   = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SUBSPACES = 2'd0;
   localparam logic [1:0] CSR_CENTROIDS = 2'd1;
   localparam logic [1:0] CSR_SUB_DIM   = 2'd2;

   localparam int VAL_W  = 16;
   localparam int DIFF_W = 17;
   localparam int SQ_W   = 33;
   localparam int SUM_W  = 37;
   localparam int ACC_W  = 40;

   // result kinds
   localparam logic KIND_CODE = 1'b0;
   localparam logic KIND_DIST = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   // tag that travels with each codebook read down the pipeline
   typedef struct packed {
      logic       dmode;
      logic       zero;
      logic       first_j;
      logic       last_j;
      logic       first_c;
      logic [7:0] code;
   } tag_type;

endpackage

/* rtl/core/pqe_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqe_if
// channel interfaces: request, response and register write
// ----------------------------------------------------------------------------
interface pqe_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  func;
   logic signed [15:0] value;
   logic        [15:0] load_index;
   logic        [7:0]  query_code;
   modport source (output valid, func, value, load_index, query_code, input ready);
   modport sink (input valid, func, value, load_index, query_code, output ready);
endinterface

interface pqe_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  chosen_code;
   logic [3:0]  subspace;
   logic [39:0] distance;
   logic        last;
   modport source (output valid, kind, chosen_code, subspace, distance, last, input ready);
   modport sink (input valid, kind, chosen_code, subspace, distance, last, output ready);
endinterface

interface pqe_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] addr;
   logic [8:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

/* rtl/core/product_quantizer_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// product_quantizer_encoder
// product quantization encoder and asymmetric distance unit, Q8.8 in
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  req     | in  | valid/ready       | func, value, load_index, query_code
//  rsp     | out | valid/ready       | kind, chosen_code, subspace, distance, last
//  csr     | in  | valid/ready(=1)   | addr, wdata
//
//  load, func 3 and non-closing encode transactions leave the controller idle.
//  a closing encode transaction sweeps K centroids of E+1 elements each:
//  one codebook read per cycle through the codebook read port.
//  a distance transaction reads a single codebook word (read, diff, square, add).
//  reset is synchronous; the codebook has no clearing pass.
//  a stalled rsp holds its result; requests are still taken, a later result waits.
// ----------------------------------------------------------------------------
module product_quantizer_encoder #(
   parameter int MAX_SUBSPACES = 8,
   parameter int MAX_CENTROIDS = 256,
   parameter int MAX_SUB_DIM   = 8
) (
   input logic clock,
   input logic reset,
   pqe_req_if.sink   req_ch,
   pqe_rsp_if.source rsp_ch,
   pqe_csr_if.sink   csr_ch
);
   import pqe_pkg::*;

   `include "product_quantizer_encoder_assert.svh"

   localparam int STORE_DEPTH = MAX_SUBSPACES * MAX_CENTROIDS * MAX_SUB_DIM;
   localparam int AW = $clog2(STORE_DEPTH);

   // configuration
   logic [4:0] m_cfg_ff, d_cfg_ff;
   logic [8:0] k_cfg_ff;
   logic [4:0] m_eff, d_eff;
   logic [8:0] k_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_cfg_ff <= 5'd8;
         k_cfg_ff <= 9'd256;
         d_cfg_ff <= 5'd8;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            CSR_SUBSPACES: m_cfg_ff <= csr_ch.wdata[4:0];
            CSR_CENTROIDS: k_cfg_ff <= csr_ch.wdata;
            CSR_SUB_DIM:   d_cfg_ff <= csr_ch.wdata[4:0];
            default: ;
         endcase
      end
   end
   assign csr_ch.ready = 1'b1;

   // clamp to the supported ranges
   always_comb begin
      m_eff = (m_cfg_ff == 5'd0) ? 5'd1 :
              (m_cfg_ff > 5'(MAX_SUBSPACES)) ? 5'(MAX_SUBSPACES) : m_cfg_ff;
      k_eff = (k_cfg_ff == 9'd0) ? 9'd1 :
              (k_cfg_ff > 9'(MAX_CENTROIDS)) ? 9'(MAX_CENTROIDS) : k_cfg_ff;
      d_eff = (d_cfg_ff == 5'd0) ? 5'd1 :
              (d_cfg_ff > 5'(MAX_SUB_DIM)) ? 5'(MAX_SUB_DIM) : d_cfg_ff;
   end

   // state
   state_type state_ff, state_in;
   logic [3:0]  e_ff, s_ff;
   logic [ACC_W-1:0] acc_ff;
   logic signed [VAL_W-1:0] buf_ff [16];
   logic [VAL_W-1:0] cb_mem [STORE_DEPTH];
   logic [VAL_W-1:0] cb_rd_ff;

   // job snapshot
   logic       job_dist_ff, job_vec_end_ff, job_out_ff;
   logic [3:0] job_e_ff, job_s_ff;
   logic [7:0] job_k_last_ff;
   logic signed [VAL_W-1:0] job_val_ff;

   // sequencer
   logic [7:0] c_ff;
   logic [3:0] j_ff;
   logic       a_vld_ff;
   tag_type    a_tag_ff, a_tag_in;
   logic signed [VAL_W-1:0] a_x_ff;
   logic [31:0] addr_full;

   // reduction
   logic [SUM_W-1:0] dsum_ff, best_ff, new_sum;
   logic [7:0]       best_c_ff;
   logic [ACC_W:0]   acc_sum;

   // response register
   logic        rsp_vld_ff, rsp_kind_ff, rsp_last_ff;
   logic [7:0]  rsp_code_ff;
   logic [3:0]  rsp_sub_ff;
   logic [ACC_W-1:0] rsp_dist_ff;

   logic             sq_busy, sq_vld;
   tag_type          sq_tag;
   logic [SQ_W-1:0]  sq;

   logic accept, is_enc, is_dist, sub_end, vec_end, last_j, last_c, out_free;
   logic [8:0] code_sat;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept  = req_ch.valid & req_ch.ready;
   assign is_enc  = req_ch.func == FUNC_ENCODE;
   assign is_dist = req_ch.func == FUNC_DIST;
   assign sub_end = (5'(e_ff) + 5'd1) >= d_eff;
   assign vec_end = sub_end & ((5'(s_ff) + 5'd1) >= m_eff);
   assign code_sat = (9'(req_ch.query_code) >= 9'(MAX_CENTROIDS)) ?
                     9'(MAX_CENTROIDS - 1) : 9'(req_ch.query_code);
   assign last_j = (j_ff == job_e_ff);
   assign last_c = (c_ff == job_k_last_ff);
   assign out_free = ~rsp_vld_ff | rsp_ch.ready;

   // codebook port: loads write, the sequencer reads
   assign addr_full = (32'(job_s_ff) * 32'(MAX_CENTROIDS) + 32'(c_ff)) * 32'(MAX_SUB_DIM)
                      + 32'(j_ff);
   always_ff @(posedge clock) begin
      if (accept && req_ch.func == FUNC_LOAD && 32'(req_ch.load_index) < 32'(STORE_DEPTH))
         cb_mem[req_ch.load_index[AW-1:0]] <= req_ch.value;
      cb_rd_ff <= cb_mem[addr_full[AW-1:0]];
   end

   // sub-vector buffer
   always_ff @(posedge clock) begin
      if (accept && is_enc) buf_ff[e_ff] <= req_ch.value;
   end

   // controller
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && ((is_enc && sub_end) || is_dist)) state_in = ST_ISSUE;
         end
         ST_ISSUE: if (last_j && last_c) state_in = ST_DRAIN;
         ST_DRAIN: if (!a_vld_ff && !sq_busy && !sq_vld) state_in = ST_DONE;
         ST_DONE:  if (!job_out_ff || out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      a_tag_in.dmode   = job_dist_ff;
      a_tag_in.zero    = (32'(j_ff) >= 32'(MAX_SUB_DIM)) ||
                         (32'(job_s_ff) >= 32'(MAX_SUBSPACES));
      a_tag_in.first_j = (j_ff == 4'd0);
      a_tag_in.last_j  = last_j;
      a_tag_in.first_c = (c_ff == 8'd0);
      a_tag_in.code    = c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         e_ff     <= 4'd0;
         s_ff     <= 4'd0;
         a_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         a_vld_ff <= (state_ff == ST_ISSUE);
         // shared element and subspace counters
         if (accept && (is_enc || is_dist)) begin
            if (sub_end) begin
               e_ff <= 4'd0;
               s_ff <= vec_end ? 4'd0 : s_ff + 4'd1;
            end else begin
               e_ff <= e_ff + 4'd1;
            end
         end
      end
      // job snapshot and sweep start
      if (accept) begin
         job_dist_ff    <= is_dist;
         job_vec_end_ff <= vec_end;
         job_out_ff     <= is_dist ? vec_end : sub_end;
         job_e_ff       <= e_ff;
         job_s_ff       <= s_ff;
         job_val_ff     <= req_ch.value;
         job_k_last_ff  <= is_dist ? code_sat[7:0] : 8'(k_eff - 9'd1);
         c_ff           <= is_dist ? code_sat[7:0] : 8'd0;
         j_ff           <= is_dist ? e_ff : 4'd0;
      end else if (state_ff == ST_ISSUE) begin
         if (last_j) begin
            j_ff <= 4'd0;
            c_ff <= c_ff + 8'd1;
         end else begin
            j_ff <= j_ff + 4'd1;
         end
      end
      a_tag_ff <= a_tag_in;
      a_x_ff   <= job_dist_ff ? job_val_ff : buf_ff[j_ff];
   end

   pqe_sq_stage u_sq (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (a_vld_ff),
      .in_tag  (a_tag_ff),
      .in_x    (a_x_ff),
      .in_cb   (cb_rd_ff),
      .busy    (sq_busy),
      .out_vld (sq_vld),
      .out_tag (sq_tag),
      .out_sq  (sq)
   );

   // running sum, best centroid, accumulator with saturation
   assign new_sum = sq_tag.first_j ? SUM_W'(sq) : dsum_ff + SUM_W'(sq);
   assign acc_sum = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(sq);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (state_ff == ST_DONE && state_in == ST_IDLE && job_vec_end_ff) begin
         acc_ff <= '0;
      end else if (sq_vld && sq_tag.dmode) begin
         acc_ff <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end
      if (sq_vld && !sq_tag.dmode) begin
         dsum_ff <= new_sum;
         if (sq_tag.last_j && (sq_tag.first_c || new_sum < best_ff)) begin
            best_ff   <= new_sum;
            best_c_ff <= sq_tag.code;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (state_ff == ST_DONE && job_out_ff && out_free) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (state_ff == ST_DONE && job_out_ff && out_free) begin
         rsp_kind_ff <= job_dist_ff ? KIND_DIST : KIND_CODE;
         rsp_code_ff <= job_dist_ff ? 8'd0 : best_c_ff;
         rsp_sub_ff  <= job_s_ff;
         rsp_dist_ff <= job_dist_ff ? acc_ff : '0;
         rsp_last_ff <= job_vec_end_ff;
      end
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.chosen_code = rsp_code_ff;
   assign rsp_ch.subspace    = rsp_sub_ff;
   assign rsp_ch.distance    = rsp_dist_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // checks
   `PQE_ASSERT_NOW(a_sq_in_sweep, clock, reset, sq_vld, (state_ff == ST_ISSUE) || (state_ff == ST_DRAIN))
   `PQE_ASSERT_NEXT(a_sweep_starts, clock, reset, accept && is_enc && sub_end, state_ff == ST_ISSUE)
   `PQE_ASSERT_NOW(a_dist_shape, clock, reset, rsp_vld_ff && rsp_kind_ff, rsp_last_ff && (rsp_code_ff == 8'd0))
endmodule

/* rtl/core/pqe_sq_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqe_sq_stage
// two register stages: element difference, then its square
// ----------------------------------------------------------------------------
module pqe_sq_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  pqe_pkg::tag_type     in_tag,
   input  logic signed [15:0]   in_x,
   input  logic signed [15:0]   in_cb,
   output logic                 busy,
   output logic                 out_vld,
   output pqe_pkg::tag_type     out_tag,
   output logic [32:0]          out_sq
);
   import pqe_pkg::*;

   logic                     d_vld_ff, s_vld_ff;
   tag_type                  d_tag_ff, s_tag_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic        [SQ_W-1:0]   sq_ff;
   logic signed [2*DIFF_W-1:0] prod;

   // difference, codebook word forced to zero outside the store
   always_comb begin
      diff_in = DIFF_W'(in_x) - (in_tag.zero ? DIFF_W'(0) : DIFF_W'(in_cb));
   end

   assign prod = diff_ff * diff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= in_vld;
         s_vld_ff <= d_vld_ff;
      end
      d_tag_ff <= in_tag;
      diff_ff  <= diff_in;
      s_tag_ff <= d_tag_ff;
      sq_ff    <= prod[SQ_W-1:0];
   end

   assign busy    = d_vld_ff | s_vld_ff;
   assign out_vld = s_vld_ff;
   assign out_tag = s_tag_ff;
   assign out_sq  = sq_ff;
endmodule
